[hw/rtl/assert_macros.svh]
// assertion macros shared by the parser rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

[hw/rtl/fpp_pkg.sv]
// shared types and constants of the framed packet parser
// no dependencies
package fpp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_VERSION,
        PH_DEST,
        PH_SRC,
        PH_LEN,
        PH_PAYLOAD,
        PH_TRAILER
    } t_phase;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_DATA     = 3'd1,
        ST_GOOD     = 3'd2,
        ST_BAD      = 3'd3,
        ST_OVERSIZE = 3'd4
    } t_status;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREAMBLE = 2'd0,
        CFG_TRAILER  = 2'd1,
        CFG_MAX_LEN  = 2'd2
    } t_cfg_idx;

    localparam logic [31:0] MAX_LEN_RESET = 32'd256;

    // window request from the parser to the preamble matcher
    typedef struct packed {
        logic       watch;
        logic [7:0] rx_byte;
    } t_win_req;

endpackage

[hw/rtl/fpp_in_if.sv]
// received byte channel of the framed packet parser
// no dependencies
interface fpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

[hw/rtl/fpp_out_if.sv]
// result channel of the framed packet parser
// depends on fpp_pkg
interface fpp_out_if;
    logic              valid;
    logic              ready;
    fpp_pkg::t_status  status;
    logic [7:0]        data;
    logic [31:0]       byte_offset;
    logic [7:0]        version;
    logic [15:0]       dest_id;
    logic [15:0]       src_id;
    logic [31:0]       length;

    modport source (output valid, output status, output data, output byte_offset,
                    output version, output dest_id, output src_id, output length,
                    input ready);
    modport sink (input valid, input status, input data, input byte_offset,
                  input version, input dest_id, input src_id, input length,
                  output ready);
endinterface

[hw/rtl/framed_packet_parser_top.sv]
// top level of the framed packet parser: input stage, header/payload/trailer parse, result register
// depends on fpp_pkg, fpp_in_if, fpp_out_if, fpp_window and assert_macros.svh
//
// usage
// i_in carries one received byte per request, o_out one result per byte: a status
// (nothing, payload byte, packet good, trailer mismatch, oversize), the payload byte
// with its offset, and the current header fields. every byte gives exactly one result
// a byte is registered in the input stage and parsed from there into the result register,
// which holds each result until o_out takes it
// throughput is one byte per cycle unless o_out stalls; the parse is a phase decode,
// 32-bit length and payload count compares, and the start window compare between the two registers
// when o_out stalls the result holds and the input stage still takes one more byte;
// i_in.ready then falls until the result is taken
// reset clears the phase, counters, header fields, start window and the preamble and
// trailer patterns, and sets the payload limit to 256
// configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata while no byte
// is in flight; index 0 preamble, 1 trailer, 2 payload limit, 3 ignored
`include "assert_macros.svh"

module framed_packet_parser_top #(
    parameter int START_LEN = 7,
    parameter int END_LEN   = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fpp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fpp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    fpp_in_if.sink                         i_in,
    fpp_out_if.source                      o_out
);

    localparam int CW  = $clog2(END_LEN + 1);
    localparam int TIW = (END_LEN > 1) ? $clog2(END_LEN) : 1;

    // configuration
    logic [63:0] r_pre_pat;
    logic [63:0] r_trl_pat;
    logic [31:0] r_max_len;

    // stages
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic        advance;

    // parse state
    fpp_pkg::t_phase r_phase, s_phase, n_phase;
    logic [1:0]      r_fc, s_fc, n_fc;
    logic [31:0]     r_pay_cnt, s_pay_cnt, n_pay_cnt;
    logic [7:0]      r_hdr_version, n_hdr_version;
    logic [15:0]     r_hdr_dest, n_hdr_dest;
    logic [15:0]     r_hdr_src, n_hdr_src;
    logic [31:0]     r_hdr_length, s_hdr_length, n_hdr_length;
    logic [CW-1:0]   r_trl_cnt, s_trl_cnt, n_trl_cnt;
    logic [7:0]      r_trl_store [END_LEN];
    logic [7:0]      n_trl_store [END_LEN];

    // result
    fpp_pkg::t_status r_status, n_status;
    logic [7:0]       r_data, n_data;
    logic [31:0]      r_offset, n_offset;

    logic              trl_take;
    logic              trl_ok;
    fpp_pkg::t_win_req win_req;
    logic              win_hit;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_pat <= '0;
            r_trl_pat <= '0;
            r_max_len <= fpp_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fpp_pkg::CFG_PREAMBLE: r_pre_pat <= i_cfg_wdata;
                fpp_pkg::CFG_TRAILER:  r_trl_pat <= i_cfg_wdata;
                fpp_pkg::CFG_MAX_LEN:  r_max_len <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // phase step, before the preamble restart
    always_comb begin
        s_phase       = r_phase;
        s_fc          = r_fc;
        s_pay_cnt     = r_pay_cnt;
        s_hdr_length  = r_hdr_length;
        s_trl_cnt     = r_trl_cnt;
        n_hdr_version = r_hdr_version;
        n_hdr_dest    = r_hdr_dest;
        n_hdr_src     = r_hdr_src;
        n_trl_store   = r_trl_store;
        n_status      = fpp_pkg::ST_NONE;
        n_data        = 8'h00;
        n_offset      = 32'h0;
        trl_take      = 1'b0;
        trl_ok        = 1'b1;

        unique case (r_phase)
            fpp_pkg::PH_VERSION: begin
                n_hdr_version = r_in_byte;
                s_phase       = fpp_pkg::PH_DEST;
            end
            fpp_pkg::PH_DEST: begin
                if (r_fc == 2'd0) begin
                    n_hdr_dest = {r_in_byte, 8'h00};
                    s_fc       = 2'd1;
                end else begin
                    n_hdr_dest = {r_hdr_dest[15:8], r_in_byte};
                    s_fc       = 2'd0;
                    s_phase    = fpp_pkg::PH_SRC;
                end
            end
            fpp_pkg::PH_SRC: begin
                if (r_fc == 2'd0) begin
                    n_hdr_src = {r_in_byte, 8'h00};
                    s_fc      = 2'd1;
                end else begin
                    n_hdr_src = {r_hdr_src[15:8], r_in_byte};
                    s_fc      = 2'd0;
                    s_phase   = fpp_pkg::PH_LEN;
                end
            end
            fpp_pkg::PH_LEN: begin
                // length is cleared on restart, so each byte fills its own lane
                case (r_fc)
                    2'd0:    s_hdr_length[31:24] = r_in_byte;
                    2'd1:    s_hdr_length[23:16] = r_in_byte;
                    2'd2:    s_hdr_length[15:8]  = r_in_byte;
                    default: s_hdr_length[7:0]   = r_in_byte;
                endcase
                if (r_fc == 2'd3) begin
                    s_fc = 2'd0;
                    if (s_hdr_length > r_max_len) begin
                        n_status = fpp_pkg::ST_OVERSIZE;
                        s_phase  = fpp_pkg::PH_IDLE;
                    end else begin
                        s_phase = fpp_pkg::PH_PAYLOAD;
                    end
                end else begin
                    s_fc = r_fc + 2'd1;
                end
            end
            fpp_pkg::PH_PAYLOAD: begin
                if (r_hdr_length == 32'h0) begin
                    s_phase  = fpp_pkg::PH_TRAILER;
                    trl_take = 1'b1;
                end else begin
                    if (r_pay_cnt < r_hdr_length) begin
                        n_status  = fpp_pkg::ST_DATA;
                        n_data    = r_in_byte;
                        n_offset  = r_pay_cnt;
                        s_pay_cnt = r_pay_cnt + 32'd1;
                    end
                    if (s_pay_cnt == r_hdr_length) begin
                        s_phase = fpp_pkg::PH_TRAILER;
                    end
                end
            end
            fpp_pkg::PH_TRAILER: begin
                trl_take = 1'b1;
            end
            default: ;
        endcase

        if (trl_take) begin
            if (r_trl_cnt < CW'(END_LEN)) begin
                for (int i = 0; i < END_LEN; i++) begin
                    if (TIW'(i) == r_trl_cnt[TIW-1:0]) begin
                        n_trl_store[i] = r_in_byte;
                    end
                end
                s_trl_cnt = r_trl_cnt + 1'b1;
            end
            for (int i = 0; i < END_LEN; i++) begin
                if (n_trl_store[i] != r_trl_pat[8*(END_LEN-1-i) +: 8]) begin
                    trl_ok = 1'b0;
                end
            end
            if (s_trl_cnt == CW'(END_LEN)) begin
                s_phase  = fpp_pkg::PH_IDLE;
                n_status = trl_ok ? fpp_pkg::ST_GOOD : fpp_pkg::ST_BAD;
            end
        end
    end

    assign win_req.watch   = advance && (s_phase != fpp_pkg::PH_PAYLOAD);
    assign win_req.rx_byte = r_in_byte;

    fpp_window #(
        .START_LEN (START_LEN)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (win_req),
        .i_pattern (r_pre_pat),
        .o_hit     (win_hit)
    );

    // preamble restart wins over the phase step
    always_comb begin
        n_phase      = s_phase;
        n_fc         = s_fc;
        n_pay_cnt    = s_pay_cnt;
        n_hdr_length = s_hdr_length;
        n_trl_cnt    = s_trl_cnt;
        if (win_hit) begin
            n_phase      = fpp_pkg::PH_VERSION;
            n_fc         = 2'd0;
            n_pay_cnt    = 32'h0;
            n_hdr_length = 32'h0;
            n_trl_cnt    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= fpp_pkg::PH_IDLE;
            r_fc          <= 2'd0;
            r_pay_cnt     <= 32'h0;
            r_hdr_version <= 8'h00;
            r_hdr_dest    <= 16'h0;
            r_hdr_src     <= 16'h0;
            r_hdr_length  <= 32'h0;
            r_trl_cnt     <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (!r_out_valid || o_out.ready) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_phase       <= n_phase;
                r_fc          <= n_fc;
                r_pay_cnt     <= n_pay_cnt;
                r_hdr_version <= n_hdr_version;
                r_hdr_dest    <= n_hdr_dest;
                r_hdr_src     <= n_hdr_src;
                r_hdr_length  <= n_hdr_length;
                r_trl_cnt     <= n_trl_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.rx_byte;
        end
        if (advance) begin
            r_trl_store <= n_trl_store;
            r_status    <= n_status;
            r_data      <= n_data;
            r_offset    <= n_offset;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.data        = r_data;
    assign o_out.byte_offset = r_offset;
    assign o_out.version     = r_hdr_version;
    assign o_out.dest_id     = r_hdr_dest;
    assign o_out.src_id      = r_hdr_src;
    assign o_out.length      = r_hdr_length;

    `ASSERT_CLK(a_pay_bound, i_clk, i_rst_n, r_phase == fpp_pkg::PH_PAYLOAD |-> (r_pay_cnt < r_hdr_length || r_hdr_length == 32'h0), "payload count past length")
    `ASSERT_CLK(a_trl_bound, i_clk, i_rst_n, r_phase == fpp_pkg::PH_TRAILER |-> r_trl_cnt < CW'(END_LEN), "trailer count full while collecting")
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, (r_in_valid && !advance) |=> r_in_valid, "input stage dropped a request")
    `ASSERT_CLK(a_oversize_src, i_clk, i_rst_n, (advance && n_status == fpp_pkg::ST_OVERSIZE) |-> r_phase == fpp_pkg::PH_LEN, "oversize outside length field")

endmodule

[hw/rtl/fpp_window.sv]
// sliding start window and preamble matcher, filled first then shifted
// depends on fpp_pkg and assert_macros.svh
`include "assert_macros.svh"

module fpp_window #(
    parameter int START_LEN = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fpp_pkg::t_win_req i_req,
    input  logic [63:0]       i_pattern,
    output logic              o_hit
);

    localparam int FW = $clog2(START_LEN + 1);

    logic [7:0]    r_win [START_LEN];
    logic [7:0]    n_win [START_LEN];
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic          match;

    always_comb begin
        n_win  = r_win;
        n_fill = r_fill;
        if (i_req.watch) begin
            if (r_fill < FW'(START_LEN)) begin
                for (int i = 0; i < START_LEN; i++) begin
                    if (FW'(i) == r_fill) begin
                        n_win[i] = i_req.rx_byte;
                    end
                end
                n_fill = r_fill + 1'b1;
            end else begin
                for (int i = 0; i < START_LEN - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[START_LEN-1] = i_req.rx_byte;
            end
        end
    end

    // first window byte against the most significant used pattern byte
    always_comb begin
        match = 1'b1;
        for (int i = 0; i < START_LEN; i++) begin
            if (n_win[i] != i_pattern[8*(START_LEN-1-i) +: 8]) begin
                match = 1'b0;
            end
        end
    end

    assign o_hit = i_req.watch && match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < START_LEN; i++) begin
                r_win[i] <= 8'h00;
            end
            r_fill <= '0;
        end else begin
            r_win  <= n_win;
            r_fill <= n_fill;
        end
    end

    `ASSERT_NEVER(a_fill_bound, i_clk, i_rst_n, r_fill > FW'(START_LEN), "window fill overrun")
    `ASSERT_CLK(a_fill_hold, i_clk, i_rst_n, !i_req.watch |=> r_fill == $past(r_fill), "window fill moved without a byte")

endmodule
